>>> sv/sdiu_pkg.sv
package sdiu_pkg;

    // One request as it arrives on the input channel.
    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] mem_address;
        logic [7:0]  write_data;
        logic [3:0]  reg_number;
        logic [15:0] instr_word;
        logic [5:0]  pixel_x;
        logic [4:0]  pixel_y;
    } t_in_s;

    // One result as it leaves on the output channel.
    typedef struct packed {
        logic [11:0] prog_counter;
        logic [11:0] index_value;
        logic [7:0]  collision_flag;
        logic        pixel_value;
        logic        unsupported;
    } t_out_s;

    typedef enum logic [1:0] {
        F_WMEM = 2'd0,
        F_WREG = 2'd1,
        F_EXEC = 2'd2,
        F_PIX  = 2'd3
    } t_func;

    localparam logic [15:0] OP_CLS    = 16'h00E0;
    localparam logic [3:0]  OP_JMP    = 4'h1;
    localparam logic [3:0]  OP_SETI   = 4'hA;
    localparam logic [3:0]  OP_DRAW   = 4'hD;
    localparam logic [3:0]  VF_IDX    = 4'hF;

    localparam int FONT_BYTES = 80;
    localparam int MOD_SHIFT  = 16;

    localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // Datapath actions, one per control word.
    typedef enum logic [4:0] {
        D_NOP,
        D_IDLE,
        D_INIT_ZERO,
        D_INIT_FONT,
        D_WMEM,
        D_WREG,
        D_CLS,
        D_JMP,
        D_SETI,
        D_BAD,
        D_PIX_RD,
        D_PIX_SEL,
        D_RD_VX,
        D_MODQ_X,
        D_MODR_X,
        D_MODQ_Y,
        D_MODR_Y,
        D_DRAW_RD,
        D_DRAW_WR,
        D_DRAW_END,
        D_DONE
    } t_dop;

    // Branch conditions of the sequencer.
    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_MEM_MORE,
        JC_FONT_MORE,
        JC_ROWS_DONE,
        JC_OUT_BUSY,
        JC_DISPATCH
    } t_jcond;

    // Microprogram step addresses.
    typedef enum logic [4:0] {
        U_INIT_MEM,
        U_INIT_FONT,
        U_IDLE,
        U_WMEM,
        U_WREG,
        U_CLS,
        U_JMP,
        U_SETI,
        U_BAD,
        U_PIX_RD,
        U_PIX_SEL,
        U_DRAW_VX,
        U_DRAW_QX,
        U_DRAW_RX,
        U_DRAW_QY,
        U_DRAW_RY,
        U_DRAW_RD,
        U_DRAW_WR,
        U_DRAW_END,
        U_DONE
    } t_upc;

    // Two-address control word: go to tgt when the condition holds, else alt (dispatch goes to the decoded entry step).
    typedef struct packed {
        t_dop   dop;
        t_jcond cond;
        t_upc   tgt;
        t_upc   alt;
    } t_ctrl_s;

    typedef struct packed {
        logic mem_more;
        logic font_more;
        logic rows_done;
    } t_stat_s;

    function automatic t_ctrl_s cw(t_dop d, t_jcond c, t_upc t, t_upc a);
        t_ctrl_s w;
        w.dop  = d;
        w.cond = c;
        w.tgt  = t;
        w.alt  = a;
        return w;
    endfunction

    // The microprogram.
    function automatic t_ctrl_s ucode(t_upc u);
        t_ctrl_s w;
        case (u)
            U_INIT_MEM:  w = cw(D_INIT_ZERO, JC_MEM_MORE,  U_INIT_MEM,  U_INIT_FONT);
            U_INIT_FONT: w = cw(D_INIT_FONT, JC_FONT_MORE, U_INIT_FONT, U_IDLE);
            U_IDLE:      w = cw(D_IDLE,      JC_DISPATCH,  U_IDLE,      U_IDLE);
            U_WMEM:      w = cw(D_WMEM,      JC_ALWAYS,    U_DONE,      U_DONE);
            U_WREG:      w = cw(D_WREG,      JC_ALWAYS,    U_DONE,      U_DONE);
            U_CLS:       w = cw(D_CLS,       JC_ALWAYS,    U_DONE,      U_DONE);
            U_JMP:       w = cw(D_JMP,       JC_ALWAYS,    U_DONE,      U_DONE);
            U_SETI:      w = cw(D_SETI,      JC_ALWAYS,    U_DONE,      U_DONE);
            U_BAD:       w = cw(D_BAD,       JC_ALWAYS,    U_DONE,      U_DONE);
            U_PIX_RD:    w = cw(D_PIX_RD,    JC_ALWAYS,    U_PIX_SEL,   U_PIX_SEL);
            U_PIX_SEL:   w = cw(D_PIX_SEL,   JC_ALWAYS,    U_DONE,      U_DONE);
            U_DRAW_VX:   w = cw(D_RD_VX,     JC_ALWAYS,    U_DRAW_QX,   U_DRAW_QX);
            U_DRAW_QX:   w = cw(D_MODQ_X,    JC_ALWAYS,    U_DRAW_RX,   U_DRAW_RX);
            U_DRAW_RX:   w = cw(D_MODR_X,    JC_ALWAYS,    U_DRAW_QY,   U_DRAW_QY);
            U_DRAW_QY:   w = cw(D_MODQ_Y,    JC_ALWAYS,    U_DRAW_RY,   U_DRAW_RY);
            U_DRAW_RY:   w = cw(D_MODR_Y,    JC_ALWAYS,    U_DRAW_RD,   U_DRAW_RD);
            U_DRAW_RD:   w = cw(D_DRAW_RD,   JC_ROWS_DONE, U_DRAW_END,  U_DRAW_WR);
            U_DRAW_WR:   w = cw(D_DRAW_WR,   JC_ALWAYS,    U_DRAW_RD,   U_DRAW_RD);
            U_DRAW_END:  w = cw(D_DRAW_END,  JC_ALWAYS,    U_DONE,      U_DONE);
            U_DONE:      w = cw(D_DONE,      JC_OUT_BUSY,  U_DONE,      U_IDLE);
            default:     w = cw(D_NOP,       JC_ALWAYS,    U_IDLE,      U_IDLE);
        endcase
        return w;
    endfunction

    // Entry step of the microprogram for a new request.
    function automatic t_upc decode(logic [1:0] func, logic [15:0] instr);
        t_upc u;
        case (t_func'(func))
            F_WMEM: u = U_WMEM;
            F_WREG: u = U_WREG;
            F_PIX:  u = U_PIX_RD;
            F_EXEC: begin
                if (instr == OP_CLS) begin
                    u = U_CLS;
                end else if (instr[15:12] == OP_JMP) begin
                    u = U_JMP;
                end else if (instr[15:12] == OP_SETI) begin
                    u = U_SETI;
                end else if (instr[15:12] == OP_DRAW) begin
                    u = U_DRAW_VX;
                end else begin
                    u = U_BAD;
                end
            end
            default: u = U_BAD;
        endcase
        return u;
    endfunction

endpackage

>>> sv/sdiu_ram.sv
module sdiu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/sdiu_useq.sv
module sdiu_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [1:0]        i_func,
    input  logic [15:0]       i_instr,
    input  sdiu_pkg::t_stat_s i_stat,
    input  logic              i_out_busy,
    output sdiu_pkg::t_dop    o_dop,
    output logic              o_idle
);
    import sdiu_pkg::*;

    t_upc    r_upc;
    t_upc    n_upc;
    t_ctrl_s w_ctrl;
    logic    w_cond;

    always_comb begin
        w_ctrl = ucode(r_upc);
    end

    // Next step.
    always_comb begin
        case (w_ctrl.cond)
            JC_ALWAYS:    w_cond = 1'b1;
            JC_MEM_MORE:  w_cond = i_stat.mem_more;
            JC_FONT_MORE: w_cond = i_stat.font_more;
            JC_ROWS_DONE: w_cond = i_stat.rows_done;
            JC_OUT_BUSY:  w_cond = i_out_busy;
            JC_DISPATCH:  w_cond = i_take;
            default:      w_cond = 1'b1;
        endcase
        if (w_ctrl.cond == JC_DISPATCH) begin
            n_upc = w_cond ? decode(i_func, i_instr) : r_upc;
        end else begin
            n_upc = w_cond ? w_ctrl.tgt : w_ctrl.alt;
        end
    end

    // Outputs.
    always_comb begin
        o_dop  = w_ctrl.dop;
        o_idle = (r_upc == U_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_INIT_MEM;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

>>> sv/sdiu_dpath.sv
module sdiu_dpath #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int MEMORY_BYTES  = 4096,
    parameter int PROGRAM_START = 512,
    parameter int FONT_START    = 80
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdiu_pkg::t_dop    i_dop,
    input  sdiu_pkg::t_in_s   i_req,
    output sdiu_pkg::t_stat_s o_stat,
    output sdiu_pkg::t_out_s  o_result
);
    import sdiu_pkg::*;

    localparam int MW  = $clog2(MEMORY_BYTES);
    localparam int XW  = $clog2(SCREEN_WIDTH);
    localparam int YW  = $clog2(SCREEN_HEIGHT);
    localparam int YCW = $clog2(SCREEN_HEIGHT + 1);
    localparam int W   = SCREEN_WIDTH;

    localparam logic [MW-1:0] FONT_BASE = MW'(FONT_START % MEMORY_BYTES);
    localparam logic [MW-1:0] MEM_LAST  = MW'(MEMORY_BYTES - 1);
    localparam logic [13:0]   RECIP_W   = 14'((2**MOD_SHIFT + SCREEN_WIDTH - 1) / SCREEN_WIDTH);
    localparam logic [13:0]   RECIP_H   = 14'((2**MOD_SHIFT + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT);
    localparam logic [7:0]    DIV_W     = 8'(SCREEN_WIDTH);
    localparam logic [7:0]    DIV_H     = 8'(SCREEN_HEIGHT);

    // Reduces a 12-bit address into memory; at most three wraps are possible.
    function automatic logic [MW-1:0] mem_wrap(input logic [11:0] a);
        logic [13:0] t;
        t = {2'b00, a};
        if (t >= 14'(2 * MEMORY_BYTES)) begin
            t = t - 14'(2 * MEMORY_BYTES);
        end
        if (t >= 14'(MEMORY_BYTES)) begin
            t = t - 14'(MEMORY_BYTES);
        end
        return t[MW-1:0];
    endfunction

    // Architectural state.
    logic [MW-1:0]            r_cnt;
    logic [MW-1:0]            r_font_addr;
    logic [11:0]              r_pc;
    logic [11:0]              r_index;
    logic [7:0]               r_vf;
    logic [15:0]              r_reg_valid;
    logic [SCREEN_HEIGHT-1:0] r_fb_valid;
    logic                     r_unsup;
    logic                     r_pix;

    // Working registers of the current request.
    logic                     r_reg_rvalid;
    logic                     r_fb_rvalid;
    logic [7:0]               r_mod_v;
    logic [4:0]               r_mod_q;
    logic [XW-1:0]            r_x0;
    logic [YCW-1:0]           r_y;
    logic [MW-1:0]            r_row_addr;
    logic [3:0]               r_row_cnt;
    logic                     r_hit;

    // Memory ports.
    logic          pm_we, pm_re;
    logic [MW-1:0] pm_waddr, pm_raddr;
    logic [7:0]    pm_wdata, pm_rdata;
    logic          rg_we, rg_re;
    logic [3:0]    rg_waddr, rg_raddr;
    logic [7:0]    rg_wdata, rg_rdata;
    logic          fb_we, fb_re;
    logic [YW-1:0] fb_waddr, fb_raddr;
    logic [W-1:0]  fb_wdata, fb_rdata;

    logic [7:0]    w_reg_rd;
    logic [W-1:0]  w_fb_row;
    logic [21:0]   w_prod;
    logic [7:0]    w_rem;
    logic [7:0]    w_rev;
    logic [W+7:0]  w_wide;
    logic [W-1:0]  w_mask;
    logic [7:0]    w_px8;
    logic [7:0]    w_py8;
    logic          w_on_screen;
    logic          w_fb_rsel_ok;

    sdiu_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_pmem (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (pm_wdata),
        .i_re    (pm_re),
        .i_raddr (pm_raddr),
        .o_rdata (pm_rdata)
    );

    sdiu_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
        .i_clk   (i_clk),
        .i_we    (rg_we),
        .i_waddr (rg_waddr),
        .i_wdata (rg_wdata),
        .i_re    (rg_re),
        .i_raddr (rg_raddr),
        .o_rdata (rg_rdata)
    );

    sdiu_ram #(.WIDTH(W), .DEPTH(SCREEN_HEIGHT)) u_fbuf (
        .i_clk   (i_clk),
        .i_we    (fb_we),
        .i_waddr (fb_waddr),
        .i_wdata (fb_wdata),
        .i_re    (fb_re),
        .i_raddr (fb_raddr),
        .o_rdata (fb_rdata)
    );

    // Unwritten registers and rows read as zero; a clear resets only the rows.
    assign w_reg_rd = r_reg_rvalid ? rg_rdata : 8'h00;
    assign w_fb_row = r_fb_rvalid ? fb_rdata : '0;

    assign w_px8       = {2'b00, i_req.pixel_x};
    assign w_py8       = {3'b000, i_req.pixel_y};
    assign w_on_screen = (w_px8 < DIV_W) && (w_py8 < DIV_H);

    // Quotient by reciprocal, then remainder in the following step.
    assign w_prod = 22'(w_reg_rd) * 22'((i_dop == D_MODQ_Y) ? RECIP_H : RECIP_W);
    assign w_rem  = r_mod_v - (8'(r_mod_q) * ((i_dop == D_MODR_Y) ? DIV_H : DIV_W));

    // Sprite bit 7 lands at column x0; columns past the right edge fall off.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_rev[i] = pm_rdata[7-i];
        end
        w_wide = {{W{1'b0}}, w_rev} << r_x0;
        w_mask = w_wide[W-1:0];
    end

    always_comb begin
        pm_we    = 1'b0;
        pm_waddr = r_cnt;
        pm_wdata = 8'h00;
        pm_re    = 1'b0;
        pm_raddr = r_row_addr;
        rg_we    = 1'b0;
        rg_waddr = i_req.reg_number;
        rg_wdata = i_req.write_data;
        rg_re    = 1'b0;
        rg_raddr = i_req.instr_word[11:8];
        fb_we    = 1'b0;
        fb_waddr = r_y[YW-1:0];
        fb_wdata = w_fb_row ^ w_mask;
        fb_re    = 1'b0;
        fb_raddr = r_y[YW-1:0];
        case (i_dop)
            D_INIT_ZERO: begin
                pm_we = 1'b1;
            end
            D_INIT_FONT: begin
                pm_we    = 1'b1;
                pm_waddr = r_font_addr;
                pm_wdata = GLYPHS[r_cnt[6:0]];
            end
            D_WMEM: begin
                pm_we    = 1'b1;
                pm_waddr = mem_wrap(i_req.mem_address);
                pm_wdata = i_req.write_data;
            end
            D_WREG: begin
                rg_we = 1'b1;
            end
            D_PIX_RD: begin
                fb_re    = 1'b1;
                fb_raddr = w_py8[YW-1:0];
            end
            D_RD_VX: begin
                rg_re = 1'b1;
            end
            D_MODQ_X: begin
                rg_re    = 1'b1;
                rg_raddr = i_req.instr_word[7:4];
            end
            D_DRAW_RD: begin
                pm_re = 1'b1;
                fb_re = 1'b1;
            end
            D_DRAW_WR: begin
                fb_we = 1'b1;
            end
            D_DRAW_END: begin
                rg_we    = 1'b1;
                rg_waddr = VF_IDX;
                rg_wdata = {7'b0, r_hit};
            end
            default: begin
            end
        endcase
    end

    assign w_fb_rsel_ok = (int'(fb_raddr) < SCREEN_HEIGHT);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_font_addr <= FONT_BASE;
            r_pc        <= 12'(PROGRAM_START);
            r_index     <= '0;
            r_vf        <= '0;
            r_reg_valid <= '0;
            r_fb_valid  <= '0;
            r_unsup     <= 1'b0;
            r_pix       <= 1'b0;
        end else begin
            case (i_dop)
                D_INIT_ZERO: begin
                    r_cnt <= (r_cnt == MEM_LAST) ? '0 : r_cnt + 1'b1;
                end
                D_INIT_FONT: begin
                    r_cnt       <= r_cnt + 1'b1;
                    r_font_addr <= (r_font_addr == MEM_LAST) ? '0 : r_font_addr + 1'b1;
                end
                D_IDLE: begin
                    r_unsup <= 1'b0;
                    r_pix   <= 1'b0;
                end
                D_WREG: begin
                    r_reg_valid[i_req.reg_number] <= 1'b1;
                    if (i_req.reg_number == VF_IDX) begin
                        r_vf <= i_req.write_data;
                    end
                end
                D_CLS: begin
                    r_fb_valid <= '0;
                end
                D_JMP: begin
                    r_pc <= i_req.instr_word[11:0];
                end
                D_SETI: begin
                    r_index <= i_req.instr_word[11:0];
                end
                D_BAD: begin
                    r_unsup <= 1'b1;
                end
                D_PIX_SEL: begin
                    r_pix <= w_on_screen & w_fb_row[w_px8[XW-1:0]];
                end
                D_DRAW_WR: begin
                    r_fb_valid[r_y[YW-1:0]] <= 1'b1;
                end
                D_DRAW_END: begin
                    r_reg_valid[VF_IDX] <= 1'b1;
                    r_vf                <= {7'b0, r_hit};
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (rg_re) begin
            r_reg_rvalid <= r_reg_valid[rg_raddr];
        end
        if (fb_re) begin
            r_fb_rvalid <= w_fb_rsel_ok && r_fb_valid[fb_raddr];
        end
        case (i_dop)
            D_RD_VX: begin
                r_row_addr <= mem_wrap(r_index);
                r_row_cnt  <= '0;
                r_hit      <= 1'b0;
            end
            D_MODQ_X, D_MODQ_Y: begin
                r_mod_v <= w_reg_rd;
                r_mod_q <= w_prod[20:16];
            end
            D_MODR_X: begin
                r_x0 <= w_rem[XW-1:0];
            end
            D_MODR_Y: begin
                r_y <= YCW'(w_rem);
            end
            D_DRAW_WR: begin
                r_row_addr <= (r_row_addr == MEM_LAST) ? '0 : r_row_addr + 1'b1;
                r_row_cnt  <= r_row_cnt + 1'b1;
                r_y        <= r_y + 1'b1;
                r_hit      <= r_hit | (|(w_fb_row & w_mask));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.mem_more  = (r_cnt != MEM_LAST);
        o_stat.font_more = (r_cnt != MW'(FONT_BYTES - 1));
        o_stat.rows_done = (r_row_cnt == i_req.instr_word[3:0])
                        || (r_y >= YCW'(SCREEN_HEIGHT));
        o_result.prog_counter   = r_pc;
        o_result.index_value    = r_index;
        o_result.collision_flag = r_vf;
        o_result.pixel_value    = r_pix;
        o_result.unsupported    = r_unsup;
    end

endmodule

>>> sv/sprite_display_instruction_unit_core.sv
// Sprite display and instruction unit. Each request writes a program memory
// byte, writes one of the sixteen byte registers, executes one opcode (clear
// screen, jump, set index or XOR sprite draw with collision into register F),
// or reads one framebuffer pixel; every request yields exactly one result that
// carries the program counter, the index, register F, the pixel read and an
// unsupported-opcode flag. A small microprogram in a read-only table steps a
// plain datapath with three single-port-read memories (program memory, byte
// registers, framebuffer rows). After reset the block first zeroes program
// memory one byte per cycle and then loads the 80 font bytes, holding off
// requests until both are done. A memory or register write, a clear screen,
// a jump, a set index and an unsupported opcode run one action step, a pixel
// read a row read step and a pixel select step, each before the done step. A
// sprite draw reads both coordinate registers, reduces both modulo the screen
// size, then does a read-modify-write of each visible framebuffer row through
// the framebuffer memory port. The finished result sits in an output register,
// so a new request is taken while the previous result is still stalled downstream.
module sprite_display_instruction_unit_core #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int MEMORY_BYTES  = 4096,
    parameter int PROGRAM_START = 512,
    parameter int FONT_START    = 80
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sdiu_pkg::t_in_s  i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sdiu_pkg::t_out_s o_out_data
);
    import sdiu_pkg::*;

    t_in_s   r_req;
    t_out_s  r_out_data;
    logic    r_out_valid;

    t_dop    w_dop;
    t_stat_s w_stat;
    t_out_s  w_result;
    logic    w_idle;
    logic    w_take;
    logic    w_out_busy;
    logic    w_load;

    // A request is taken only while the sequencer waits in its idle step.
    assign o_in_stall = !w_idle;
    assign w_take     = i_in_valid && !o_in_stall;

    // The result register is busy while it holds a result that is stalled.
    assign w_out_busy = r_out_valid && i_out_stall;
    assign w_load     = (w_dop == D_DONE) && !w_out_busy;

    sdiu_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_func     (i_in_data.func),
        .i_instr    (i_in_data.instr_word),
        .i_stat     (w_stat),
        .i_out_busy (w_out_busy),
        .o_dop      (w_dop),
        .o_idle     (w_idle)
    );

    sdiu_dpath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MEMORY_BYTES  (MEMORY_BYTES),
        .PROGRAM_START (PROGRAM_START),
        .FONT_START    (FONT_START)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dop    (w_dop),
        .i_req    (r_req),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    // The request is held for the whole microprogram run.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> sv/sdiu_checker.sv
module sdiu_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_stall,
    input logic             i_out_valid,
    input logic             i_out_stall,
    input sdiu_pkg::t_out_s i_out_data
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_data))
        else $error("result changed while stalled");

    // Once a request is taken, no other is taken in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("request taken while the previous one runs");

    // Right after reset the memory load is running and nothing is offered.
    a_reset_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> i_in_stall && !i_out_valid)
        else $error("block active right after reset");

    // A pixel read never flags an unsupported opcode.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.pixel_value && i_out_data.unsupported))
        else $error("pixel and unsupported flag both set");

endmodule

bind sprite_display_instruction_unit_core sdiu_checker u_sdiu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
